// File: sv/assert_macros.svh
// Assertion helpers used by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/twbb_pkg.sv
`timescale 1ns / 1ps

package twbb_pkg;

    localparam int RING_DEPTH = 2048;

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);

    localparam int MODE_W = 4;
    localparam int LON_W  = 32;
    localparam int LAT_W  = 31;
    localparam int HDG_W  = 16;

    // One ring entry: {fix_valid, lat, lon}.
    localparam int ENTRY_W = 1 + LAT_W + LON_W;

    localparam int S_TDATA_RAW = 2 * LON_W + 2 * LAT_W + HDG_W;
    localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int S_TUSER_W   = MODE_W + 2;

    localparam int M_TDATA_RAW = 2 * CNT_W + 2 * LON_W + 2 * LAT_W + HDG_W;
    localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TUSER_W   = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_FINISH
    } twbb_state_t;

    typedef struct packed {
        logic push;
        logic rd_issue;
        logic finish;
    } twbb_cmd_t;

    typedef struct packed {
        logic last_read;
        logic out_free;
    } twbb_sts_t;

endpackage

// File: sv/twbb_ram.sv
`timescale 1ns / 1ps

module twbb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/twbb_controller.sv
`timescale 1ns / 1ps

module twbb_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output twbb_pkg::twbb_cmd_t  cmd,
    input  twbb_pkg::twbb_sts_t  sts
);

    twbb_pkg::twbb_state_t state_reg;
    twbb_pkg::twbb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= twbb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            twbb_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = twbb_pkg::ST_SCAN;
                end
            end
            twbb_pkg::ST_SCAN:
            begin
                if (sts.last_read)
                begin
                    state_next = twbb_pkg::ST_FLUSH;
                end
            end
            twbb_pkg::ST_FLUSH:
            begin
                state_next = twbb_pkg::ST_FINISH;
            end
            twbb_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = twbb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = twbb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd.push     = 1'b0;
        cmd.rd_issue = 1'b0;
        cmd.finish   = 1'b0;
        case (state_reg)
            twbb_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.push = s_tvalid;
            end
            twbb_pkg::ST_SCAN:
            begin
                cmd.rd_issue = 1'b1;
            end
            twbb_pkg::ST_FLUSH:
            begin
                cmd.rd_issue = 1'b0;
            end
            twbb_pkg::ST_FINISH:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/twbb_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module twbb_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  twbb_pkg::twbb_cmd_t                cmd,
    output twbb_pkg::twbb_sts_t                sts,
    input  logic [twbb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [twbb_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [twbb_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [twbb_pkg::M_TUSER_W-1:0]     m_tuser
);

    localparam int SLOT_W = twbb_pkg::SLOT_W;
    localparam int CNT_W  = twbb_pkg::CNT_W;
    localparam int MODE_W = twbb_pkg::MODE_W;
    localparam int LON_W  = twbb_pkg::LON_W;
    localparam int LAT_W  = twbb_pkg::LAT_W;
    localparam int HDG_W  = twbb_pkg::HDG_W;

    // Input beat fields.
    logic [MODE_W-1:0]       in_mode;
    logic                    in_fix_valid;
    logic                    in_dest_valid;
    logic signed [LON_W-1:0] in_lon;
    logic signed [LAT_W-1:0] in_lat;
    logic [HDG_W-1:0]        in_hdg;
    logic signed [LON_W-1:0] in_dlon;
    logic signed [LAT_W-1:0] in_dlat;

    assign in_mode       = s_tuser[MODE_W-1:0];
    assign in_fix_valid  = s_tuser[MODE_W];
    assign in_dest_valid = s_tuser[MODE_W+1];
    assign in_lon        = s_tdata[LON_W-1:0];
    assign in_lat        = s_tdata[LON_W +: LAT_W];
    assign in_hdg        = s_tdata[LON_W+LAT_W +: HDG_W];
    assign in_dlon       = s_tdata[LON_W+LAT_W+HDG_W +: LON_W];
    assign in_dlat       = s_tdata[2*LON_W+LAT_W+HDG_W +: LAT_W];

    // Track state.
    logic [MODE_W-1:0] mode_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic              first_reg;
    logic              first_next;
    logic [HDG_W-1:0]  hdg_reg;
    logic [HDG_W-1:0]  hdg_next;

    logic              dvalid_reg;
    logic signed [LON_W-1:0] dlon_reg;
    logic signed [LAT_W-1:0] dlat_reg;

    logic signed [LON_W-1:0] box_lon_lo_reg;
    logic signed [LON_W-1:0] box_lon_hi_reg;
    logic signed [LAT_W-1:0] box_lat_lo_reg;
    logic signed [LAT_W-1:0] box_lat_hi_reg;

    logic              mode_change;
    logic [SLOT_W-1:0] slot_eff;
    logic [CNT_W-1:0]  fill_eff;
    logic              ring_full;

    // A mode change empties the ring before this fix goes in.
    always_comb
    begin
        mode_change = (in_mode != mode_reg);
        slot_eff    = mode_change ? '0 : slot_reg;
        fill_eff    = mode_change ? '0 : fill_reg;
        ring_full   = (fill_eff == CNT_W'(twbb_pkg::RING_DEPTH));

        if (fill_eff == '0)
        begin
            first_next = in_fix_valid;
        end
        else if (ring_full)
        begin
            first_next = 1'b0;
        end
        else
        begin
            first_next = first_reg;
        end

        if (in_fix_valid)
        begin
            hdg_next = in_hdg;
        end
        else
        begin
            hdg_next = mode_change ? '0 : hdg_reg;
        end

        slot_next = (slot_eff == SLOT_W'(twbb_pkg::RING_DEPTH - 1)) ?
                    '0 : slot_eff + SLOT_W'(1);
        fill_next = ring_full ? fill_eff : fill_eff + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= '0;
            slot_reg       <= '0;
            fill_reg       <= '0;
            first_reg      <= 1'b0;
            hdg_reg        <= '0;
        end
        else if (cmd.push)
        begin
            mode_reg       <= in_mode;
            slot_reg       <= slot_next;
            fill_reg       <= fill_next;
            first_reg      <= first_next;
            hdg_reg        <= hdg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            dvalid_reg <= in_dest_valid;
            dlon_reg   <= in_dlon;
            dlat_reg   <= in_dlat;
        end
    end

    // Ring storage.
    logic [twbb_pkg::ENTRY_W-1:0] ram_wdata;
    logic [twbb_pkg::ENTRY_W-1:0] ram_rdata;
    logic [SLOT_W-1:0]            rd_idx_reg;
    logic                         rd_pending_reg;

    assign ram_wdata = {in_fix_valid, in_lat, in_lon};

    twbb_ram #(
        .WIDTH (twbb_pkg::ENTRY_W),
        .DEPTH (twbb_pkg::RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (slot_eff),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    logic                    rd_flag;
    logic signed [LON_W-1:0] rd_lon;
    logic signed [LAT_W-1:0] rd_lat;

    assign rd_lon  = ram_rdata[LON_W-1:0];
    assign rd_lat  = ram_rdata[LON_W +: LAT_W];
    assign rd_flag = ram_rdata[LON_W+LAT_W];

    assign sts.last_read = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg     <= '0;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            rd_pending_reg <= cmd.rd_issue;
            if (cmd.push)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.rd_issue)
            begin
                rd_idx_reg <= rd_idx_reg + SLOT_W'(1);
            end
        end
    end

    // Running min/max over the valid entries, one read beat per cycle.
    logic [CNT_W-1:0]        acc_cnt_reg;
    logic signed [LON_W-1:0] acc_lon_lo_reg;
    logic signed [LON_W-1:0] acc_lon_hi_reg;
    logic signed [LAT_W-1:0] acc_lat_lo_reg;
    logic signed [LAT_W-1:0] acc_lat_hi_reg;
    logic                    acc_take;
    logic                    acc_first;

    assign acc_take  = rd_pending_reg && rd_flag;
    assign acc_first = (acc_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cnt_reg <= '0;
        end
        else if (cmd.push)
        begin
            acc_cnt_reg <= '0;
        end
        else if (acc_take)
        begin
            acc_cnt_reg <= acc_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_take)
        begin
            if (acc_first || (rd_lon < acc_lon_lo_reg))
            begin
                acc_lon_lo_reg <= rd_lon;
            end
            if (acc_first || (rd_lon > acc_lon_hi_reg))
            begin
                acc_lon_hi_reg <= rd_lon;
            end
            if (acc_first || (rd_lat < acc_lat_lo_reg))
            begin
                acc_lat_lo_reg <= rd_lat;
            end
            if (acc_first || (rd_lat > acc_lat_hi_reg))
            begin
                acc_lat_hi_reg <= rd_lat;
            end
        end
    end

    // Final box: widened by the destination when one is in use.
    logic                    have_fix;
    logic signed [LON_W-1:0] fin_lon_lo;
    logic signed [LON_W-1:0] fin_lon_hi;
    logic signed [LAT_W-1:0] fin_lat_lo;
    logic signed [LAT_W-1:0] fin_lat_hi;

    always_comb
    begin
        have_fix   = (acc_cnt_reg != '0);
        fin_lon_lo = (dvalid_reg && (dlon_reg < acc_lon_lo_reg)) ? dlon_reg : acc_lon_lo_reg;
        fin_lon_hi = (dvalid_reg && (dlon_reg > acc_lon_hi_reg)) ? dlon_reg : acc_lon_hi_reg;
        fin_lat_lo = (dvalid_reg && (dlat_reg < acc_lat_lo_reg)) ? dlat_reg : acc_lat_lo_reg;
        fin_lat_hi = (dvalid_reg && (dlat_reg > acc_lat_hi_reg)) ? dlat_reg : acc_lat_hi_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_lon_lo_reg <= '0;
            box_lon_hi_reg <= '0;
            box_lat_lo_reg <= '0;
            box_lat_hi_reg <= '0;
        end
        else if (cmd.finish && have_fix)
        begin
            box_lon_lo_reg <= fin_lon_lo;
            box_lon_hi_reg <= fin_lon_hi;
            box_lat_lo_reg <= fin_lat_lo;
            box_lat_hi_reg <= fin_lat_hi;
        end
    end

    // Output register.
    logic                    m_tvalid_reg;
    logic [CNT_W-1:0]        out_vcount_reg;
    logic [CNT_W-1:0]        out_fill_reg;
    logic signed [LON_W-1:0] out_lon_lo_reg;
    logic signed [LON_W-1:0] out_lon_hi_reg;
    logic signed [LAT_W-1:0] out_lat_lo_reg;
    logic signed [LAT_W-1:0] out_lat_hi_reg;
    logic                    out_first_reg;
    logic [HDG_W-1:0]        out_hdg_reg;
    logic                    out_dest_reg;

    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_vcount_reg <= acc_cnt_reg;
            out_fill_reg   <= fill_reg;
            out_lon_lo_reg <= have_fix ? fin_lon_lo : box_lon_lo_reg;
            out_lon_hi_reg <= have_fix ? fin_lon_hi : box_lon_hi_reg;
            out_lat_lo_reg <= have_fix ? fin_lat_lo : box_lat_lo_reg;
            out_lat_hi_reg <= have_fix ? fin_lat_hi : box_lat_hi_reg;
            out_first_reg  <= first_reg;
            out_hdg_reg    <= hdg_reg;
            out_dest_reg   <= have_fix && dvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = twbb_pkg::M_TDATA_W'({out_hdg_reg, out_lat_hi_reg, out_lat_lo_reg,
                                            out_lon_hi_reg, out_lon_lo_reg,
                                            out_fill_reg, out_vcount_reg});
    assign m_tuser  = {out_dest_reg, out_first_reg};

    `ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_reg <= CNT_W'(twbb_pkg::RING_DEPTH),
                    "fill count above ring depth")
    `ASSERT_IMPLIES(a_count_bound, 1'b1, acc_cnt_reg <= fill_reg,
                    "valid count above fill count")
    `ASSERT_IMPLIES(a_read_in_fill, cmd.rd_issue, CNT_W'(rd_idx_reg) < fill_reg,
                    "ring read beyond filled entries")
    `ASSERT_NEXT(a_finish_valid, cmd.finish, m_tvalid_reg,
                 "result not presented after finish")

endmodule

// File: sv/track_window_bounding_box_unit.sv
// Track window bounding box unit.
// Slave channel: one beat per position fix (mode, fix flag, lon/lat, heading, destination).
// Master channel: one beat per fix with valid and stored counts, the bounding box over
// the valid fixes in the ring (widened by the destination when in use), the first-run
// flag and the latest valid heading.
// A fix is written into the ring in the cycle it is accepted. The ring is then read back
// through its single read port, one entry per cycle, from slot 0 up to the last stored
// entry; the box is then finished and the result is registered for the master channel.
// One fix is processed at a time; tready is high only while the unit is idle.
// The result sits in an output register, so a new fix may be accepted while the previous
// result is still waiting. If the receiver stalls, the unit holds its finished result in
// the last step until the output register frees up.
// Reset clears the fill count, write slot, mode, heading and box to zero; the ring memory
// itself is not cleared, since only entries written since reset or the last mode change are read.
`timescale 1ns / 1ps

module track_window_bounding_box_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // fix_lon, fix_lat, heading, dest_lon, dest_lat, zero padding
    input  logic [twbb_pkg::S_TDATA_W-1:0] s_tdata,
    // nav_mode, fix_valid, dest_valid
    input  logic [twbb_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // valid_count, stored_count, lon_min, lon_max, lat_min, lat_max, last_heading, padding
    output logic [twbb_pkg::M_TDATA_W-1:0] m_tdata,
    // first_run, dest_in_box
    output logic [twbb_pkg::M_TUSER_W-1:0] m_tuser
);

    twbb_pkg::twbb_cmd_t cmd;
    twbb_pkg::twbb_sts_t sts;

    twbb_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    twbb_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
